### design/packet_resync_byte_buffer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for packet_resync_byte_buffer
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef PACKET_RESYNC_BYTE_BUFFER_MACROS_SVH
`define PACKET_RESYNC_BYTE_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRBB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRBB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/prbb_pkg.sv
// ----------------------------------------------------------------------------
// prbb_pkg
// Types, codes and default sizes shared by the receive byte buffer modules.
// ----------------------------------------------------------------------------
package prbb_pkg;

   localparam int BUFFER_BYTES_DEFAULT    = 2048;
   localparam int MAX_START_CHARS_DEFAULT = 4;
   localparam int QUEUE_DEPTH             = 2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int START_COUNT_WIDTH = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_A     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_COUNT = 3'd4;

   // command codes
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_RESYNC = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_NO_START = 2'd2;

   typedef enum logic [1:0] {
      OP_APPEND_FIRST,
      OP_APPEND_NEXT,
      OP_RESYNC
   } op_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic        chunk_first;
      logic [11:0] chunk_length;
      logic [31:0] rx_seconds;
      logic [19:0] rx_microseconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] fill_level;
      logic [7:0]  head_byte;
      logic [31:0] last_seconds;
      logic [19:0] last_microseconds;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [11:0] chunk_length;
      logic [31:0] rx_seconds;
      logic [19:0] rx_microseconds;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/prbb_front.sv
// ----------------------------------------------------------------------------
// prbb_front
// Takes command beats, decodes them into jobs and hands them to the queue.
// ----------------------------------------------------------------------------
module prbb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  prbb_pkg::req_type          req_data,
   input  prbb_pkg::queue_status_type q_status,
   output logic                       busy,
   output logic                       q_push,
   output prbb_pkg::job_type          q_job
);
   import prbb_pkg::*;

   logic    hold_ff, hold_in;
   job_type job_ff, job_in;
   logic    accept;

   assign busy   = reset || (hold_ff && q_status.full);
   assign accept = start && !busy;
   assign q_push = hold_ff && !q_status.full;
   assign q_job  = job_ff;

   always_comb begin
      hold_in = accept || (hold_ff && !q_push);
      job_in  = job_ff;
      if (accept) begin
         job_in.data_byte       = req_data.data_byte;
         job_in.chunk_length    = req_data.chunk_length;
         job_in.rx_seconds      = req_data.rx_seconds;
         job_in.rx_microseconds = req_data.rx_microseconds;
         if (req_data.cmd == CMD_RESYNC) begin
            job_in.op = OP_RESYNC;
         end else if (req_data.chunk_first) begin
            job_in.op = OP_APPEND_FIRST;
         end else begin
            job_in.op = OP_APPEND_NEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

### design/prbb_queue.sv
// ----------------------------------------------------------------------------
// prbb_queue
// Short job queue between the decode front and the buffer engine.
// ----------------------------------------------------------------------------
module prbb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  prbb_pkg::job_type          push_job,
   input  logic                       pop,
   output prbb_pkg::job_type          head_job,
   output prbb_pkg::queue_status_type status
);
   import prbb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/prbb_back.sv
// ----------------------------------------------------------------------------
// prbb_back
// Buffer engine: circular byte store, appends, overflow and start-byte hunt.
// ----------------------------------------------------------------------------
module prbb_back #(
   parameter int BUFFER_BYTES    = prbb_pkg::BUFFER_BYTES_DEFAULT,
   parameter int MAX_START_CHARS = prbb_pkg::MAX_START_CHARS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  prbb_pkg::job_type                      q_job,
   input  prbb_pkg::queue_status_type             q_status,
   output logic                                   q_pop,
   input  logic [MAX_START_CHARS-1:0][7:0]        start_chars,
   input  logic [prbb_pkg::START_COUNT_WIDTH-1:0] start_count,
   output logic                                   rsp_valid,
   output prbb_pkg::rsp_type                      rsp_data
);
   import prbb_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int FW = $clog2(BUFFER_BYTES + 1);
   localparam int SW = ((FW > 12) ? FW : 12) + 1;
   localparam logic [FW:0]   WRAP_SIZE = BUFFER_BYTES[FW:0];
   localparam logic [FW-1:0] FULL_FILL = BUFFER_BYTES[FW-1:0];
   localparam logic [SW-1:0] FIRST_CAP = BUFFER_BYTES[SW-1:0];

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          drop_ff, drop_in;
   logic [31:0]   sec_ff, sec_in;
   logic [19:0]   usec_ff, usec_in;
   logic [7:0]    head_byte_ff, head_byte_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] iss_ff, iss_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [FW-1:0] rd_off_ff, rd_off_in;

   logic [7:0]    store_mem [BUFFER_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;

   logic [START_COUNT_WIDTH-1:0] sat_count;
   logic                         start_hit;
   logic [SW-1:0]                first_sum;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [FW-1:0] b);
      logic [FW:0] sum;
      sum = (FW+1)'(a) + (FW+1)'(b);
      if (sum >= WRAP_SIZE) begin
         sum = sum - WRAP_SIZE;
      end
      return sum[AW-1:0];
   endfunction

   // compare the byte just read against the enabled start characters
   always_comb begin
      sat_count = (start_count > START_COUNT_WIDTH'(MAX_START_CHARS)) ?
                  START_COUNT_WIDTH'(MAX_START_CHARS) : start_count;
      start_hit = 1'b0;
      for (int i = 0; i < MAX_START_CHARS; i++) begin
         if ((START_COUNT_WIDTH'(i) < sat_count) && (start_chars[i] == rd_data_ff)) begin
            start_hit = 1'b1;
         end
      end
   end

   assign first_sum = SW'(fill_ff) + SW'(q_job.chunk_length);
   assign mem_waddr = wrap_add(head_ff, fill_ff);
   assign mem_raddr = wrap_add(head_ff, iss_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      sec_in       = sec_ff;
      usec_in      = usec_ff;
      head_byte_in = head_byte_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      iss_in       = iss_ff;
      rd_valid_in  = 1'b0;
      rd_off_in    = rd_off_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               status_in = STATUS_OK;
               case (q_job.op)
                  OP_APPEND_FIRST, OP_APPEND_NEXT: begin
                     rsp_valid_in = 1'b1;
                     sec_in       = q_job.rx_seconds;
                     usec_in      = q_job.rx_microseconds;
                     if ((q_job.op == OP_APPEND_FIRST && first_sum > FIRST_CAP) ||
                         (q_job.op == OP_APPEND_NEXT && !drop_ff && fill_ff == FULL_FILL)) begin
                        // overflow: clear and drop the rest of the chunk
                        head_in      = '0;
                        fill_in      = '0;
                        head_byte_in = '0;
                        drop_in      = 1'b1;
                        status_in    = STATUS_OVERFLOW;
                     end else if ((q_job.op == OP_APPEND_FIRST && q_job.chunk_length != '0) ||
                                  (q_job.op == OP_APPEND_NEXT && !drop_ff)) begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + FW'(1);
                        if (fill_ff == '0) begin
                           head_byte_in = q_job.data_byte;
                        end
                     end
                     if (q_job.op == OP_APPEND_FIRST && first_sum <= FIRST_CAP) begin
                        drop_in = 1'b0;
                     end
                  end
                  OP_RESYNC: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        head_in      = '0;
                        status_in    = STATUS_NO_START;
                     end else begin
                        state_in = S_SCAN;
                        iss_in   = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one read issued and one byte checked per cycle
            if (iss_ff < fill_ff) begin
               rd_valid_in = 1'b1;
               rd_off_in   = iss_ff;
               iss_in      = iss_ff + FW'(1);
            end
            if (rd_valid_ff) begin
               if (start_hit) begin
                  head_in      = wrap_add(head_ff, rd_off_ff);
                  fill_in      = fill_ff - rd_off_ff;
                  head_byte_in = rd_data_ff;
                  status_in    = STATUS_OK;
                  rsp_valid_in = 1'b1;
                  rd_valid_in  = 1'b0;
                  state_in     = S_IDLE;
               end else if ((rd_off_ff + FW'(1)) == fill_ff) begin
                  head_in      = '0;
                  fill_in      = '0;
                  head_byte_in = '0;
                  status_in    = STATUS_NO_START;
                  rsp_valid_in = 1'b1;
                  rd_valid_in  = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         sec_ff       <= '0;
         usec_ff      <= '0;
         head_byte_ff <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_off_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         sec_ff       <= sec_in;
         usec_ff      <= usec_in;
         head_byte_ff <= head_byte_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         rd_valid_ff  <= rd_valid_in;
         rd_off_ff    <= rd_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= q_job.data_byte;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_data.status            = status_ff;
   assign rsp_data.fill_level        = 12'(fill_ff);
   assign rsp_data.head_byte         = head_byte_ff;
   assign rsp_data.last_seconds      = sec_ff;
   assign rsp_data.last_microseconds = usec_ff;

endmodule

### design/packet_resync_byte_buffer.sv
// ----------------------------------------------------------------------------
// packet_resync_byte_buffer
// Receive byte buffer with chunk appends, overflow clearing and sync hunting.
// ----------------------------------------------------------------------------
// Command channel: a beat is taken when start is high and busy is low. Append
// beats carry one chunk byte each (length on the first beat) and the receive
// time; a resync beat drops leading bytes up to the first start character.
// Result channel: one beat per command, rsp_valid high for a single cycle with
// status, fill level, head byte and last receive time. There is no back
// pressure on results.
// CSR channel: csr_ready is always high; registers 0..3 are start characters,
// register 4 the number in use. Write them only while no command is in flight.
// A beat passes the decode register and job queue; the engine registers its
// result. A resync scans from the head for a start character, or skips the
// scan on an empty buffer. Appends run at one beat per cycle while busy is
// low; the scan reads one byte per cycle through the store's single read port.
// busy rises once the two-entry job queue and the decode register are full.
// Reset is synchronous: buffer empty, timestamps zero, start characters zero,
// one start character in use. The byte store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "packet_resync_byte_buffer_macros.svh"

module packet_resync_byte_buffer #(
   parameter int BUFFER_BYTES    = prbb_pkg::BUFFER_BYTES_DEFAULT,
   parameter int MAX_START_CHARS = prbb_pkg::MAX_START_CHARS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  prbb_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output prbb_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prbb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [prbb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import prbb_pkg::*;

   logic [MAX_START_CHARS-1:0][7:0]  start_chars_ff;
   logic [START_COUNT_WIDTH-1:0]     start_count_ff;

   logic             q_push, q_pop;
   job_type          q_in_job, q_out_job;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_chars_ff <= '0;
         start_count_ff <= START_COUNT_WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_START_COUNT) begin
            start_count_ff <= csr_wdata[START_COUNT_WIDTH-1:0];
         end
         for (int i = 0; i < MAX_START_CHARS; i++) begin
            if (csr_index == CSR_START_A + CSR_INDEX_WIDTH'(i)) begin
               start_chars_ff[i] <= csr_wdata;
            end
         end
      end
   end

   prbb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .q_status (q_status),
      .busy     (busy),
      .q_push   (q_push),
      .q_job    (q_in_job)
   );

   prbb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head_job (q_out_job),
      .status   (q_status)
   );

   prbb_back #(
      .BUFFER_BYTES    (BUFFER_BYTES),
      .MAX_START_CHARS (MAX_START_CHARS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_job       (q_out_job),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .start_chars (start_chars_ff),
      .start_count (start_count_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   `PRBB_ASSERT_IMP(a_no_start_clears, clock, reset, rsp_valid && rsp_data.status == STATUS_NO_START, rsp_data.fill_level == '0, "no-start result left bytes held")
   `PRBB_ASSERT_IMP(a_overflow_clears, clock, reset, rsp_valid && rsp_data.status == STATUS_OVERFLOW, rsp_data.fill_level == '0 && rsp_data.head_byte == '0, "overflow result left bytes held")
   `PRBB_ASSERT_IMP(a_no_push_when_full, clock, reset, q_push, !q_status.full, "job pushed into a full queue")
   `PRBB_ASSERT_NXT(a_push_fills_queue, clock, reset, q_push, !q_status.empty, "queue empty after a push")

endmodule
